FILE: sv/rr3_pkg.sv
// Shared types, constants and digit helpers for the square repacker.
package rr3_pkg;

  localparam int GROUP_SQUARES = 20;
  localparam int SQ_BITS       = 2 * GROUP_SQUARES;
  localparam int R2_BYTES      = 5;
  localparam int R3_BYTES      = 4;
  localparam int R3_PER_BYTE   = 5;
  localparam int RR3_QDEPTH    = 2;

  localparam logic DIR_ENC = 1'b0;
  localparam logic DIR_DEC = 1'b1;

  localparam logic [2:0] ENC_LAST_POS = 3'(R2_BYTES - 1);
  localparam logic [2:0] DEC_LAST_POS = 3'(R3_BYTES - 1);

  localparam logic [7:0] TRIT_WEIGHT [R3_PER_BYTE] = '{8'd1, 8'd3, 8'd9, 8'd27, 8'd81};

  // One completed group of squares, tagged with the direction it was collected in.
  typedef struct packed {
    logic               dir;
    logic [SQ_BITS-1:0] squares;
  } rr3_grp_t;

  // Base-3 digits of a byte, digit k at bits 2k+1..2k. x/3 == (x*171)>>9 for 8-bit x.
  function automatic logic [2*R3_PER_BYTE-1:0] rr3_trits(input logic [7:0] b);
    logic [7:0]               v;
    logic [15:0]              p;
    logic [7:0]               q;
    logic [2*R3_PER_BYTE-1:0] d;
    v = b;
    d = '0;
    for (int k = 0; k < R3_PER_BYTE; k++) begin
      p = 16'(v) * 16'd171;
      q = {1'b0, p[15:9]};
      d[2*k +: 2] = 2'(v - 8'(q * 8'd3));
      v = q;
    end
    return d;
  endfunction

  // Weighted sum of five squares, wrapping mod 256.
  function automatic logic [7:0] rr3_pack3(input logic [2*R3_PER_BYTE-1:0] s);
    logic [7:0] acc;
    acc = '0;
    for (int k = 0; k < R3_PER_BYTE; k++) begin
      acc = acc + 8'({6'b0, s[2*k +: 2]} * TRIT_WEIGHT[k]);
    end
    return acc;
  endfunction

endpackage

FILE: sv/rr3_front.sv
// Front end: takes input bytes, unpacks them into squares and hands off full groups.
module rr3_front
  import rr3_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_valid,
  input  logic     cfg_direction,
  input  logic     in_push,
  input  logic     [7:0] in_byte,
  output logic     in_full,
  input  logic     gq_full,
  output logic     gq_push,
  output rr3_grp_t gq_data
);

  logic               dir_r;
  logic [2:0]         pos_r, pos_nxt;
  logic [SQ_BITS-1:0] sq_r, sq_nxt;
  logic               pos_last;
  logic               accept;
  logic [5:0]         base10;

  assign pos_last = (dir_r == DIR_DEC) ? (pos_r == DEC_LAST_POS) : (pos_r == ENC_LAST_POS);
  // only the group-completing byte needs room in the queue
  assign in_full  = gq_full && pos_last;
  assign accept   = in_push && !in_full;
  assign base10   = {3'b0, pos_r} * 6'd10;

  always_comb begin
    sq_nxt = sq_r;
    if (dir_r == DIR_DEC) begin
      sq_nxt[base10 +: 2*R3_PER_BYTE] = rr3_trits(in_byte);
    end else begin
      sq_nxt[{pos_r, 3'b000} +: 8] = in_byte;
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (cfg_valid) begin
      pos_nxt = '0;
    end else if (accept) begin
      pos_nxt = pos_last ? 3'd0 : pos_r + 3'd1;
    end
  end

  assign gq_push         = accept && pos_last;
  assign gq_data.dir     = dir_r;
  assign gq_data.squares = sq_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= DIR_ENC;
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      if (cfg_valid) begin
        dir_r <= cfg_direction;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sq_r <= sq_nxt;
    end
  end

endmodule

FILE: sv/rr3_gq.sv
// Small group queue between front and back ends.
module rr3_gq
  import rr3_pkg::*;
#(
  parameter int QDEPTH = RR3_QDEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  rr3_grp_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     nonempty,
  output rr3_grp_t head
);

  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  rr3_grp_t         ent_r [QDEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(QDEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full     = (cnt_r == CW'(QDEPTH));
  assign nonempty = (cnt_r != '0);
  assign head     = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: sv/rr3_back.sv
// Back end: walks a queued group and emits target-packed bytes into the output register.
module rr3_back
  import rr3_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     gq_nonempty,
  input  rr3_grp_t gq_head,
  output logic     gq_pop,
  input  logic     out_pop,
  output logic     out_empty,
  output logic     [7:0] out_byte,
  output logic     out_group_last
);

  logic [2:0] idx_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       produce;
  logic       last;
  logic [7:0] byte_nxt;
  logic [5:0] base10;

  assign produce = gq_nonempty && (!out_valid_r || out_pop);
  // decode emits five radix-2 bytes, encode four radix-3 bytes
  assign last    = (gq_head.dir == DIR_DEC) ? (idx_r == ENC_LAST_POS) : (idx_r == DEC_LAST_POS);
  assign base10  = {3'b0, idx_r} * 6'd10;
  assign gq_pop  = produce && last;

  always_comb begin
    if (gq_head.dir == DIR_DEC) begin
      byte_nxt = gq_head.squares[{idx_r, 3'b000} +: 8];
    end else begin
      byte_nxt = rr3_pack3(gq_head.squares[base10 +: 2*R3_PER_BYTE]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (produce) begin
        idx_r       <= last ? 3'd0 : idx_r + 3'd1;
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      out_byte_r <= byte_nxt;
      out_last_r <= last;
    end
  end

  assign out_empty      = !out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_group_last = out_last_r;

endmodule

FILE: sv/radix2_radix3_square_repacker.sv
// Repacks 20-square groups between 4-per-byte radix-2 and 5-per-byte radix-3 packings.
// The front end takes one input byte per cycle unless in_full stalls it, and the back
// end emits one result byte per cycle from a registered output slot when out_pop keeps
// it drained, so encode (5 in, 4 out) runs at one input per cycle and decode
// (4 in, 5 out) is held back by the single output port. A completed group is queued
// before its first byte is registered. A direction write discards any partial group.
module radix2_radix3_square_repacker
  import rr3_pkg::*;
#(
  parameter int QDEPTH = RR3_QDEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_direction,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_byte,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_byte,
  output logic       out_group_last
);

  rr3_grp_t gq_data, gq_head;
  logic     gq_push, gq_full, gq_pop, gq_nonempty;

  assign cfg_ready = 1'b1;

  rr3_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_direction (cfg_direction),
    .in_push       (in_push),
    .in_byte       (in_byte),
    .in_full       (in_full),
    .gq_full       (gq_full),
    .gq_push       (gq_push),
    .gq_data       (gq_data)
  );

  rr3_gq #(.QDEPTH(QDEPTH)) u_gq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (gq_push),
    .push_data (gq_data),
    .full      (gq_full),
    .pop       (gq_pop),
    .nonempty  (gq_nonempty),
    .head      (gq_head)
  );

  rr3_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .gq_nonempty    (gq_nonempty),
    .gq_head        (gq_head),
    .gq_pop         (gq_pop),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_byte       (out_byte),
    .out_group_last (out_group_last)
  );

endmodule

FILE: verif/tb_top.sv
// Testbench for the radix-2 / radix-3 square repacker: queue-fed driver, monitor and predictor.
module tb_top;
  import rr3_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_AT       = 60;
  localparam int HOLD_CYCLES   = 150;

  typedef enum logic [1:0] {STEP_BYTE, STEP_DIR, STEP_DRAIN} step_kind_t;

  typedef struct packed {
    step_kind_t kind;
    logic [7:0] value;
  } step_t;

  typedef struct packed {
    logic [7:0] val;
    logic       last;
  } rep_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_direction = DIR_ENC;
  logic       in_push = 1'b0;
  logic       in_full;
  logic [7:0] in_byte = 8'h00;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic [7:0] out_byte;
  logic       out_group_last;

  step_t     plan[$];
  rep_byte_t repacked_q[$];
  int        errors = 0;

  // predictor state
  logic       dir_q = DIR_ENC;
  logic [2:0] grp_pos = '0;
  logic [1:0] sq_buf [GROUP_SQUARES];

  radix2_radix3_square_repacker dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_direction  (cfg_direction),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_byte        (in_byte),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_byte       (out_byte),
    .out_group_last (out_group_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task flag_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  // Mostly short gaps, a few long ones, and now and then a run with none.
  function automatic int idle_len(inout int run);
    int r;
    if (run > 0) begin
      run--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 8) begin
      run = $urandom_range(24, 8);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  task repack_byte(input logic [7:0] b);
    int pos;
    int acc;
    int w;
    int rest;
    rep_byte_t r;
    pos = grp_pos;
    if (dir_q == DIR_ENC) begin
      if (pos >= R2_BYTES) pos = 0;
      for (int k = 0; k < 4; k++) sq_buf[pos*4 + k] = b[2*k +: 2];
      if (pos + 1 < R2_BYTES) begin
        grp_pos = 3'(pos + 1);
      end else begin
        grp_pos = '0;
        for (int k = 0; k < R3_BYTES; k++) begin
          acc = 0;
          w = 1;
          for (int j = 0; j < R3_PER_BYTE; j++) begin
            acc += int'(sq_buf[k*R3_PER_BYTE + j]) * w;
            w *= 3;
          end
          r.val = 8'(acc);
          r.last = (k == R3_BYTES - 1);
          repacked_q.push_back(r);
        end
      end
    end else begin
      if (pos >= R3_BYTES) pos = 0;
      rest = b;
      for (int j = 0; j < R3_PER_BYTE; j++) begin
        sq_buf[pos*R3_PER_BYTE + j] = 2'(rest % 3);
        rest = rest / 3;
      end
      if (pos + 1 < R3_BYTES) begin
        grp_pos = 3'(pos + 1);
      end else begin
        grp_pos = '0;
        for (int k = 0; k < R2_BYTES; k++) begin
          r.val = {sq_buf[4*k+3], sq_buf[4*k+2], sq_buf[4*k+1], sq_buf[4*k]};
          r.last = (k == R2_BYTES - 1);
          repacked_q.push_back(r);
        end
      end
    end
  endtask

  // Driver: byte requests and direction writes, both taken from the plan.
  int tx_gap = 0;
  int tx_run = 0;
  int quiet = 0;

  always @(posedge clk) begin
    logic       push_nx;
    logic       cfg_nx;
    logic [7:0] byte_nx;
    logic       dir_nx;
    push_nx = in_push;
    cfg_nx  = cfg_valid;
    byte_nx = in_byte;
    dir_nx  = cfg_direction;
    if (rst_n) begin
      if (in_push && !in_full) begin
        repack_byte(in_byte);
        push_nx = 1'b0;
        tx_gap = idle_len(tx_run);
      end
      if (cfg_valid && cfg_ready) begin
        dir_q = cfg_direction;
        grp_pos = '0;
        cfg_nx = 1'b0;
      end
      if (!push_nx && !cfg_nx && plan.size() > 0) begin
        if (plan[0].kind == STEP_BYTE) begin
          if (tx_gap > 0) begin
            tx_gap--;
          end else begin
            push_nx = 1'b1;
            byte_nx = plan[0].value;
            void'(plan.pop_front());
          end
        end else begin
          // direction writes and drain steps only once the block has gone quiet
          quiet = (repacked_q.size() == 0) ? quiet + 1 : 0;
          if (plan[0].kind == STEP_DRAIN && quiet > 0) begin
            void'(plan.pop_front());
            quiet = 0;
          end else if (plan[0].kind == STEP_DIR && quiet >= SETTLE_CYCLES) begin
            cfg_nx = 1'b1;
            dir_nx = plan[0].value[0];
            void'(plan.pop_front());
            quiet = 0;
          end
        end
      end
    end
    in_push       <= push_nx;
    in_byte       <= byte_nx;
    cfg_valid     <= cfg_nx;
    cfg_direction <= dir_nx;
  end

  // Monitor: random pop stalls, one long hold-off to back the block up.
  int rx_stall = 0;
  int rx_run = 0;
  int hold = 0;
  int seen = 0;

  always @(posedge clk) begin
    rep_byte_t exp_b;
    logic      pop_nx;
    if (rst_n && out_pop && !out_empty) begin
      seen++;
      if (repacked_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result byte %02h last %0b", out_byte,
                                out_group_last));
      end else begin
        exp_b = repacked_q.pop_front();
        if (out_byte !== exp_b.val)
          flag_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, exp_b.val));
        if (out_group_last !== exp_b.last)
          flag_mismatch($sformatf("out_group_last %0b, expected %0b", out_group_last,
                                  exp_b.last));
      end
      rx_stall = idle_len(rx_run);
      if (seen == HOLD_AT) hold = HOLD_CYCLES;
    end
    if (!rst_n) begin
      pop_nx = 1'b0;
    end else if (hold > 0) begin
      hold--;
      pop_nx = 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      pop_nx = 1'b0;
    end else begin
      pop_nx = 1'b1;
    end
    out_pop <= pop_nx;
  end

  task add_byte(input logic [7:0] v);
    plan.push_back('{STEP_BYTE, v});
  endtask

  task add_dir(input logic d);
    plan.push_back('{STEP_DIR, {7'b0, d}});
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 8'h00;
    if (r < 16) return 8'hFF;
    if (r < 22) return 8'(241 + $urandom_range(3));
    return 8'($urandom_range(255));
  endfunction

  initial begin
    int n;
    for (int i = 0; i < GROUP_SQUARES; i++) sq_buf[i] = '0;

    // encode: all four square values, then a partial group dropped by a rewrite
    add_dir(DIR_ENC);
    add_byte(8'h00); add_byte(8'hFF); add_byte(8'hE4); add_byte(8'h1B); add_byte(8'h55);
    add_byte(8'hAA); add_byte(8'hFF);
    add_dir(DIR_ENC);
    for (int i = 0; i < R2_BYTES; i++) add_byte(8'hFF);   // all threes, sum wraps
    // decode: digit extremes, 242 is all twos, 243 rolls past five digits
    add_dir(DIR_DEC);
    add_byte(8'd0); add_byte(8'd255); add_byte(8'd242); add_byte(8'd243);
    add_byte(8'd1); add_byte(8'd80);
    add_dir(DIR_DEC);
    add_byte(8'd121); add_byte(8'd3); add_byte(8'd26); add_byte(8'd254);

    for (int ph = 0; ph < 4; ph++) begin
      add_dir(ph[0] ? DIR_DEC : DIR_ENC);
      n = $urandom_range(30, 20);
      for (int i = 0; i < n; i++) begin
        if (ph == 1 && i == n / 2) plan.push_back('{STEP_DRAIN, 8'h00});
        add_byte(pick_byte());
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (plan.size() > 0 || in_push || cfg_valid) @(posedge clk);
    while (repacked_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (repacked_q.size() > 0)
      flag_mismatch($sformatf("%0d expected bytes never came out", repacked_q.size()));
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule
